// File: rtl/core/tgard_pkg.sv
`default_nettype none

package tgard_pkg;

  // Header layout
  localparam int unsigned HDR_LEN = 18;
  localparam logic [4:0] HPOS_TYPE  = 5'd2;
  localparam logic [4:0] HPOS_W_LO  = 5'd12;
  localparam logic [4:0] HPOS_W_HI  = 5'd13;
  localparam logic [4:0] HPOS_H_LO  = 5'd14;
  localparam logic [4:0] HPOS_H_HI  = 5'd15;
  localparam logic [4:0] HPOS_DEPTH = 5'd16;
  localparam logic [4:0] HPOS_LAST  = 5'(HDR_LEN - 1);
  localparam logic [4:0] HPOS_DONE  = 5'(HDR_LEN);

  localparam logic [7:0] TYPE_INDEXED = 8'd1;
  localparam logic [7:0] TYPE_RAW     = 8'd2;
  localparam logic [7:0] TYPE_RLE     = 8'd10;
  localparam logic [7:0] DEPTH24      = 8'd24;
  localparam logic [7:0] DEPTH32      = 8'd32;
  localparam logic [7:0] OPAQUE       = 8'hFF;

  localparam int unsigned PKT_FLAG_BIT = 7;

  localparam logic [2:0] BPP_BAD = 3'd0;
  localparam logic [2:0] BPP24   = 3'd3;
  localparam logic [2:0] BPP32   = 3'd4;

  localparam int unsigned EVQ_DEPTH  = 4;
  localparam int unsigned EVQ_AW     = $clog2(EVQ_DEPTH);
  localparam int unsigned RESQ_DEPTH = 2;
  localparam int unsigned RESQ_AW    = $clog2(RESQ_DEPTH);

  // Quotient of one row advance fits in 8 bits (span count is at most 128)
  localparam int unsigned QUO_W  = 8;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  typedef enum logic [1:0] {
    PM_HEADER = 2'd0,
    PM_REPEAT = 2'd1,
    PM_RAW    = 2'd2
  } pkt_mode_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_HDR_OK  = 2'd1,
    EV_HDR_ERR = 2'd2,
    EV_SPAN    = 2'd3
  } ev_kind_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SPAN   = 2'd1,
    KIND_ERROR  = 2'd2
  } res_kind_e;

  typedef enum logic [1:0] {
    ERR_TRUNCATED = 2'd0,
    ERR_INDEXED   = 2'd1,
    ERR_TYPE      = 2'd2,
    ERR_DEPTH     = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_CLIP,
    BS_DIV,
    BS_LONG,
    BS_EMIT,
    BS_TRUNC
  } back_state_e;

  // Classified word from the front end
  typedef struct packed {
    ev_kind_e    kind;
    err_e        err;
    logic        eof;
    logic        rle_run;
    logic [7:0]  count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] width;
    logic [15:0] height;
  } ev_t;

  typedef struct packed {
    res_kind_e   kind;
    err_e        err;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] dest_x;
    logic [15:0] dest_row;
    logic [7:0]  count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/tgard_front.sv
`default_nettype none

module tgard_front
  import tgard_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_i,
  input  wire logic       eof_i,
  output logic            ev_valid_o,
  output ev_t             ev_o
);

  logic [4:0]  hpos_q, hpos_d;
  logic [7:0]  type_q, type_d;
  logic [2:0]  bpp_q, bpp_d;
  logic [15:0] w_q, w_d;
  logic [15:0] h_q, h_d;
  pkt_mode_e   mode_q, mode_d;
  logic [7:0]  remain_q, remain_d;
  logic [7:0]  pix_q [4];
  logic [7:0]  pix_d [4];
  logic [1:0]  bip_q, bip_d;
  logic        dead_q, dead_d;

  logic [1:0]  bip_inc;
  logic        has_ev;
  ev_t         ev;

  always_comb begin
    hpos_d   = hpos_q;
    type_d   = type_q;
    bpp_d    = bpp_q;
    w_d      = w_q;
    h_d      = h_q;
    mode_d   = mode_q;
    remain_d = remain_q;
    pix_d    = pix_q;
    bip_d    = bip_q;
    dead_d   = dead_q;
    bip_inc  = bip_q + 2'd1;
    has_ev   = 1'b0;
    ev       = '0;
    ev.kind  = EV_NONE;
    ev.eof   = eof_i;

    if (accept_i && !dead_q) begin
      if (hpos_q != HPOS_DONE) begin
        case (hpos_q)
          HPOS_TYPE:  type_d = data_i;
          HPOS_W_LO:  w_d = {w_q[15:8], data_i};
          HPOS_W_HI:  w_d = {data_i, w_q[7:0]};
          HPOS_H_LO:  h_d = {h_q[15:8], data_i};
          HPOS_H_HI:  h_d = {data_i, h_q[7:0]};
          HPOS_DEPTH: bpp_d = (data_i == DEPTH24) ? BPP24 :
                              (data_i == DEPTH32) ? BPP32 : BPP_BAD;
          default: ;
        endcase
        hpos_d = hpos_q + 5'd1;
        if (hpos_q == HPOS_LAST) begin
          has_ev = 1'b1;
          if (type_q == TYPE_INDEXED) begin
            ev.kind = EV_HDR_ERR;
            ev.err  = ERR_INDEXED;
            dead_d  = 1'b1;
          end else if (type_q != TYPE_RAW && type_q != TYPE_RLE) begin
            ev.kind = EV_HDR_ERR;
            ev.err  = ERR_TYPE;
            dead_d  = 1'b1;
          end else if (bpp_q == BPP_BAD) begin
            ev.kind = EV_HDR_ERR;
            ev.err  = ERR_DEPTH;
            dead_d  = 1'b1;
          end else begin
            ev.kind   = EV_HDR_OK;
            ev.width  = w_q;
            ev.height = h_q;
            mode_d    = (type_q == TYPE_RAW) ? PM_RAW : PM_HEADER;
          end
        end
      end else if (type_q == TYPE_RLE && mode_q == PM_HEADER) begin
        // packet header: run length and repeat flag
        remain_d = {1'b0, data_i[PKT_FLAG_BIT-1:0]} + 8'd1;
        mode_d   = data_i[PKT_FLAG_BIT] ? PM_REPEAT : PM_RAW;
        bip_d    = 2'd0;
      end else begin
        pix_d[bip_q] = data_i;
        if (({1'b0, bip_inc} >= bpp_q) || (bip_inc == 2'd0)) begin
          bip_d    = 2'd0;
          has_ev   = 1'b1;
          ev.kind  = EV_SPAN;
          ev.red   = pix_d[2];
          ev.green = pix_d[1];
          ev.blue  = pix_d[0];
          ev.alpha = (bpp_q == BPP32) ? pix_d[3] : OPAQUE;
          if (mode_q == PM_REPEAT) begin
            ev.count   = remain_q;
            ev.rle_run = 1'b1;
            mode_d     = PM_HEADER;
          end else begin
            ev.count = 8'd1;
            if (type_q == TYPE_RLE) begin
              remain_d = remain_q - 8'd1;
              if (remain_q == 8'd1) begin
                mode_d = PM_HEADER;
              end
            end
          end
        end else begin
          bip_d = bip_inc;
        end
      end
    end

    // end of file: back to reset for the next file
    if (accept_i && eof_i) begin
      hpos_d   = '0;
      type_d   = '0;
      bpp_d    = BPP_BAD;
      w_d      = '0;
      h_d      = '0;
      mode_d   = PM_HEADER;
      remain_d = '0;
      bip_d    = '0;
      dead_d   = 1'b0;
      for (int i = 0; i < 4; i++) begin
        pix_d[i] = '0;
      end
    end
  end

  assign ev_valid_o = accept_i && (has_ev || eof_i);
  assign ev_o       = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpos_q   <= '0;
      type_q   <= '0;
      bpp_q    <= BPP_BAD;
      w_q      <= '0;
      h_q      <= '0;
      mode_q   <= PM_HEADER;
      remain_q <= '0;
      bip_q    <= '0;
      dead_q   <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        pix_q[i] <= '0;
      end
    end else begin
      hpos_q   <= hpos_d;
      type_q   <= type_d;
      bpp_q    <= bpp_d;
      w_q      <= w_d;
      h_q      <= h_d;
      mode_q   <= mode_d;
      remain_q <= remain_d;
      bip_q    <= bip_d;
      dead_q   <= dead_d;
      pix_q    <= pix_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tgard_evq.sv
`default_nettype none

module tgard_evq
  import tgard_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  ev_t       data_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      empty_o,
  output ev_t       data_o
);

  ev_t               mem_q [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [EVQ_AW:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (EVQ_AW+1)'(EVQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tgard_back.sv
`default_nettype none

module tgard_back
  import tgard_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic ev_empty_i,
  input  ev_t       ev_i,
  output logic      ev_pop_o,
  input  wire logic res_pop_i,
  output logic      res_empty_o,
  output res_t      res_o
);

  back_state_e       state_q, state_d;
  logic [15:0]       w_q, w_d;
  logic [15:0]       h_q, h_d;
  logic [15:0]       col_q, col_d;
  logic [15:0]       row_q, row_d;
  logic              fin_q, fin_d;
  ev_t               evl_q, evl_d;
  logic [31:0]       prod_q, prod_d;
  logic [7:0]        cnt_q, cnt_d;
  logic [16:0]       rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;

  // result queue
  res_t               rq_mem_q [RESQ_DEPTH];
  logic [RESQ_AW-1:0] rq_wr_q, rq_rd_q;
  logic [RESQ_AW:0]   rq_cnt_q;
  logic               rq_room, rq_push, rq_pop;
  res_t               rq_in;

  // decode shared by next-state and datapath
  logic        take;
  logic        hdr_empty;
  logic        raw_wrap;
  logic [15:0] raw_row;
  logic        raw_fin;
  logic [31:0] left;
  logic [7:0]  clip_cnt;
  logic [22:0] div_shifted;
  logic        div_ge;
  logic [15:0] emit_row;
  logic        emit_fin;

  function automatic res_t mk_err(err_e code);
    res_t r;
    r      = '0;
    r.kind = KIND_ERROR;
    r.err  = code;
    r.last = 1'b1;
    return r;
  endfunction

  assign rq_room   = (rq_cnt_q != (RESQ_AW+1)'(RESQ_DEPTH));
  assign take      = (state_q == BS_IDLE) && !ev_empty_i && rq_room;
  assign hdr_empty = (ev_i.width == 16'd0) || (ev_i.height == 16'd0);
  assign raw_wrap  = ((col_q + 16'd1) == w_q);
  assign raw_row   = row_q + {15'd0, raw_wrap};
  assign raw_fin   = (raw_row >= h_q);
  assign left      = prod_q - {16'd0, col_q};
  assign clip_cnt  = (left < {24'd0, evl_q.count}) ? left[7:0] : evl_q.count;
  assign div_shifted = {7'd0, w_q} << step_q;
  assign div_ge    = ({6'd0, rem_q} >= div_shifted);
  assign emit_row  = row_q + {8'd0, quo_q};
  assign emit_fin  = (emit_row >= h_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (take) begin
          unique case (ev_i.kind)
            EV_HDR_OK: begin
              if (ev_i.eof && !hdr_empty) begin
                state_d = BS_TRUNC;
              end
            end
            EV_SPAN: begin
              if (!fin_q) begin
                if (ev_i.rle_run) begin
                  state_d = BS_CLIP;
                end else if (ev_i.eof && !raw_fin) begin
                  state_d = BS_TRUNC;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BS_CLIP: state_d = BS_DIV;
      BS_DIV: begin
        if (rem_q < {w_q, 1'b0}) begin
          state_d = BS_EMIT;
        end else begin
          state_d = BS_LONG;
        end
      end
      BS_LONG: begin
        if (step_q == '0) begin
          state_d = BS_EMIT;
        end
      end
      BS_EMIT: state_d = (evl_q.eof && !emit_fin) ? BS_TRUNC : BS_IDLE;
      BS_TRUNC: begin
        if (rq_room) begin
          state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  // datapath and result words
  always_comb begin
    w_d      = w_q;
    h_d      = h_q;
    col_d    = col_q;
    row_d    = row_q;
    fin_d    = fin_q;
    evl_d    = evl_q;
    prod_d   = prod_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    step_d   = step_q;
    ev_pop_o = 1'b0;
    rq_push  = 1'b0;
    rq_in    = '0;

    unique case (state_q)
      BS_IDLE: begin
        if (take) begin
          ev_pop_o = 1'b1;
          unique case (ev_i.kind)
            EV_NONE: begin
              if (ev_i.eof) begin
                if (!fin_q) begin
                  rq_push = 1'b1;
                  rq_in   = mk_err(ERR_TRUNCATED);
                end
                fin_d = 1'b0;
              end
            end
            EV_HDR_ERR: begin
              rq_push = 1'b1;
              rq_in   = mk_err(ev_i.err);
              fin_d   = !ev_i.eof;
            end
            EV_HDR_OK: begin
              w_d          = ev_i.width;
              h_d          = ev_i.height;
              col_d        = '0;
              row_d        = '0;
              rq_push      = 1'b1;
              rq_in.kind   = KIND_HEADER;
              rq_in.width  = ev_i.width;
              rq_in.height = ev_i.height;
              rq_in.last   = hdr_empty;
              fin_d        = hdr_empty && !ev_i.eof;
            end
            EV_SPAN: begin
              if (fin_q) begin
                // image complete: drop until end of file
                if (ev_i.eof) begin
                  fin_d = 1'b0;
                end
              end else if (ev_i.rle_run) begin
                evl_d  = ev_i;
                prod_d = {16'd0, h_q - row_q} * {16'd0, w_q};
              end else begin
                rq_push        = 1'b1;
                rq_in.kind     = KIND_SPAN;
                rq_in.width    = w_q;
                rq_in.height   = h_q;
                rq_in.dest_x   = col_q;
                rq_in.dest_row = h_q - 16'd1 - row_q;
                rq_in.count    = ev_i.count;
                rq_in.red      = ev_i.red;
                rq_in.green    = ev_i.green;
                rq_in.blue     = ev_i.blue;
                rq_in.alpha    = ev_i.alpha;
                rq_in.last     = raw_fin;
                col_d          = raw_wrap ? 16'd0 : col_q + 16'd1;
                row_d          = raw_row;
                fin_d          = raw_fin && !ev_i.eof;
              end
            end
            default: ;
          endcase
        end
      end
      BS_CLIP: begin
        // clip the run to the pixels left in the image
        cnt_d = clip_cnt;
        rem_d = {1'b0, col_q} + {9'd0, clip_cnt};
      end
      BS_DIV: begin
        quo_d  = '0;
        step_d = STEP_W'(QUO_W - 1);
        if (rem_q >= {1'b0, w_q} && rem_q < {w_q, 1'b0}) begin
          quo_d = QUO_W'(1);
          rem_d = rem_q - {1'b0, w_q};
        end
      end
      BS_LONG: begin
        if (div_ge) begin
          rem_d         = rem_q - div_shifted[16:0];
          quo_d[step_q] = 1'b1;
        end
        step_d = step_q - 1'b1;
      end
      BS_EMIT: begin
        rq_push        = 1'b1;
        rq_in.kind     = KIND_SPAN;
        rq_in.width    = w_q;
        rq_in.height   = h_q;
        rq_in.dest_x   = col_q;
        rq_in.dest_row = h_q - 16'd1 - row_q;
        rq_in.count    = cnt_q;
        rq_in.red      = evl_q.red;
        rq_in.green    = evl_q.green;
        rq_in.blue     = evl_q.blue;
        rq_in.alpha    = evl_q.alpha;
        rq_in.last     = emit_fin;
        col_d          = rem_q[15:0];
        row_d          = emit_row;
        fin_d          = emit_fin && !evl_q.eof;
      end
      BS_TRUNC: begin
        if (rq_room) begin
          rq_push = 1'b1;
          rq_in   = mk_err(ERR_TRUNCATED);
          fin_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      fin_q   <= 1'b0;
      w_q     <= '0;
      h_q     <= '0;
      col_q   <= '0;
      row_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      w_q     <= w_d;
      h_q     <= h_d;
      col_q   <= col_d;
      row_q   <= row_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evl_q  <= evl_d;
    prod_q <= prod_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  // result queue
  assign res_empty_o = (rq_cnt_q == '0);
  assign rq_pop      = res_pop_i && !res_empty_o;
  assign res_o       = rq_mem_q[rq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      if (rq_push) begin
        rq_wr_q <= rq_wr_q + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_q <= rq_rd_q + 1'b1;
      end
      if (rq_push && !rq_pop) begin
        rq_cnt_q <= rq_cnt_q + 1'b1;
      end else if (rq_pop && !rq_push) begin
        rq_cnt_q <= rq_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      rq_mem_q[rq_wr_q] <= rq_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tga_truecolor_rle_decoder_unit.sv
// Channel   Handshake          Word
// -------   ----------------   -----------------------------------------------
// input     push / full        data_byte_i, end_of_file_i
// result    empty / pop        kind_o, error_code_o, width_o, height_o, dest_x_o,
//                              dest_row_o, span_count_o, red_o .. alpha_o, last_o
//
// The front end takes one byte per cycle while its 4-word event queue has room.
// Header words and raw pixel spans are done in the idle state as they are popped;
// a repeat span goes through multiply, clip, row split and emit, plus a bit-serial
// divide when it wraps past two or more rows, which only happens for widths under 128.
// Results leave through a 2-word queue; a stalled pop holds the back end, then
// the front end once the event queue fills. Reset is immediate: no clearing pass.
`default_nettype none

module tga_truecolor_rle_decoder_unit
  import tgard_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_file_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind_o,
  output logic [1:0]       error_code_o,
  output logic [15:0]      width_o,
  output logic [15:0]      height_o,
  output logic [15:0]      dest_x_o,
  output logic [15:0]      dest_row_o,
  output logic [7:0]       span_count_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       alpha_o,
  output logic             last_o
);

  logic accept;
  logic ev_push;
  ev_t  ev_in;
  logic ev_full, ev_empty, ev_pop;
  ev_t  ev_head;
  res_t res;

  assign accept = push && !ev_full;
  assign full   = ev_full;

  tgard_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_i     (data_byte_i),
    .eof_i      (end_of_file_i),
    .ev_valid_o (ev_push),
    .ev_o       (ev_in)
  );

  tgard_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .data_i  (ev_in),
    .pop_i   (ev_pop),
    .full_o  (ev_full),
    .empty_o (ev_empty),
    .data_o  (ev_head)
  );

  tgard_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_empty_i  (ev_empty),
    .ev_i        (ev_head),
    .ev_pop_o    (ev_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign kind_o       = res.kind;
  assign error_code_o = res.err;
  assign width_o      = res.width;
  assign height_o     = res.height;
  assign dest_x_o     = res.dest_x;
  assign dest_row_o   = res.dest_row;
  assign span_count_o = res.count;
  assign red_o        = res.red;
  assign green_o      = res.green;
  assign blue_o       = res.blue;
  assign alpha_o      = res.alpha;
  assign last_o       = res.last;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_pop |-> !ev_empty)
    else $error("back end popped an empty event queue");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_ERROR) |-> last_o)
    else $error("error word not marked last");

  a_span_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_SPAN) |-> (span_count_o != 8'd0))
    else $error("span word with zero count");

  a_nonspan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_SPAN) |-> (span_count_o == 8'd0 && dest_x_o == 16'd0))
    else $error("span fields set on a non-span word");

endmodule

`default_nettype wire
